[hdl/ttsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttsc_pkg;

    localparam int SW          = 24;
    localparam int DELAY_DEPTH = 1024;
    localparam int DLY_AW      = $clog2(DELAY_DEPTH);
    localparam int SINE_SIZE   = 1024;
    localparam int SINE_AW     = $clog2(SINE_SIZE);

    localparam int DLY_MIN = 256;
    localparam int DLY_MAX = (DELAY_DEPTH - 2) * 256 - 1;

    // Q4.28 filter coefficients, feedback terms stored negated
    localparam logic signed [31:0] EMPH_B0  = 32'sd485683137;
    localparam logic signed [31:0] EMPH_B1  = -32'sd383307578;
    localparam logic signed [31:0] EMPH_NA1 = 32'sd166059891;
    localparam logic signed [31:0] DEEM_B0  = 32'sd148363392;
    localparam logic signed [31:0] DEEM_B1  = -32'sd91780756;
    localparam logic signed [31:0] DEEM_NA1 = 32'sd211852824;
    localparam logic signed [31:0] LP_B0    = 32'sd54549064;
    localparam logic signed [31:0] LP_B1    = 32'sd109098128;
    localparam logic signed [31:0] LP_B2    = 32'sd54549064;
    localparam logic signed [31:0] LP_NA1   = 32'sd103365287;
    localparam logic signed [31:0] LP_NA2   = -32'sd53125927;

    localparam logic [31:0] TAP_OFFS [3] = '{32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAB};

    localparam logic [31:0] PRESET_STEP  [4] = '{32'd35791, 32'd49213, 32'd67109, 32'd98426};
    localparam logic [15:0] PRESET_DEPTH [4] = '{16'd18432, 16'd27034, 16'd39322, 16'd55296};
    localparam logic [16:0] PRESET_MIX   [4] = '{17'd11469, 17'd14746, 17'd18022, 17'd21299};

    typedef enum logic [2:0] {
        CFG_ENABLE = 3'd0,
        CFG_MODE   = 3'd1,
        CFG_STEP   = 3'd2,
        CFG_BASE   = 3'd3,
        CFG_DEPTH  = 3'd4,
        CFG_WET    = 3'd5,
        CFG_SPREAD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                     en;
        logic [DLY_AW-1:0]        addr;
        logic signed [SW-1:0]     data;
    } t_ram_wr;

    typedef logic signed [SW-1:0] t_sine_tab [SINE_SIZE];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] SINE_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    function automatic logic signed [SW-1:0] sine_at(input logic [31:0] u);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        q = u[31:30];
        r = {34'd0, u[29:0]};
        if (q[0]) begin
            r = 64'h4000_0000 - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 0; k < 6; k++) begin
            t = ONE_Q30 - ((x2 * t) >> 30) / SINE_DIV[k];
        end
        s = (((x * t) >> 30) + 64'd64) >> 7;
        if (s > 64'd8388607) begin
            s = 64'd8388607;
        end
        return q[1] ? -SW'(s) : SW'(s);
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        for (int i = 0; i < SINE_SIZE; i++) begin
            tab[i] = sine_at(32'((64'(i) << 32) / SINE_SIZE));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] a,
                                                     input int unsigned sh);
        return (a + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // divide by 2^sh, rounding toward zero
    function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] a,
                                                       input int unsigned sh);
        if (a < 0) begin
            return (a + ((64'sd1 <<< sh) - 64'sd1)) >>> sh;
        end
        return a >>> sh;
    endfunction

    function automatic logic signed [SW-1:0] sat_smp(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end
        if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[SW-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/three_tap_stereo_chorus_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stereo chorus with three modulated taps on one shared delay store.
// Input channel: i_in_valid / o_in_stall carry one left/right sample pair per beat.
// Output channel: o_out_valid / i_out_stall carry one processed pair per beat.
// Config channel: i_cfg_valid / o_cfg_ready with a register index and 32-bit data;
// write it only while no sample is in flight.
// Processing: each processed sample comes from one pass of a sequencer around
// a single 32x32 multiplier and the delay store read port (twelve store reads,
// forty-seven multiplies). A new beat is taken only once the previous result is
// loaded, so no second pair enters while one is in flight. In bypass (disabled, or
// wet share of 3 or less) the pair goes to the output register unchanged.
// The result sits in an output register: the next input beat is taken while it
// waits, and the sequencer only holds at its final step if that register is
// still full and stalled.
// Reset: config returns to defaults, LFO phase, filter histories and write pointer
// clear, then a pass zeroes all 1024 delay store entries with the input stalled
// (config writes are taken during it).

module three_tap_stereo_chorus_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [23:0]            i_left_in,
    input  wire logic signed [23:0]            i_right_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [23:0]                 o_left_out,
    output logic signed [23:0]                 o_right_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    localparam int AW = ttsc_pkg::DLY_AW;
    localparam int SW = ttsc_pkg::SW;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE,
        S_EMP0, S_EMP1, S_EMP2, S_EMP3, S_EMP4,
        S_LFO0, S_LFO1, S_LFO2, S_LFO3, S_LFO4, S_LFO5,
        S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_RD5,
        S_HM0, S_HM1, S_HM2, S_HM3, S_HM4, S_HM5, S_HM6,
        S_LP0, S_LP1, S_LP2, S_LP3, S_LP4, S_LP5, S_LP6,
        S_DE0, S_DE1, S_DE2, S_DE3, S_DE4,
        S_MX0, S_MX1, S_MX2, S_MX3, S_MX4, S_MX5, S_MX6, S_MX7,
        S_OUT
    } t_state;

    // config registers
    logic        r_enable;
    logic [2:0]  r_mode;
    logic [31:0] r_step;
    logic [17:0] r_base;
    logic [15:0] r_depth;
    logic [15:0] r_wet;
    logic [15:0] r_spread;

    t_state                r_state;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_pos;
    logic [31:0]           r_phase;
    logic [31:0]           r_ph;
    logic [1:0]            r_k;
    logic                  r_byp;
    logic signed [SW-1:0]  r_left;
    logic signed [SW-1:0]  r_right;
    logic signed [SW-1:0]  r_x;
    logic signed [SW-1:0]  r_ex1;
    logic signed [SW-1:0]  r_ey1;
    logic signed [SW-1:0]  r_lp [3][4];
    logic signed [SW-1:0]  r_de [3][2];
    logic signed [SW-1:0]  r_tap [3];
    logic signed [SW-1:0]  r_sa;
    logic signed [SW-1:0]  r_lfo;
    logic [9:0]            r_n;
    logic [7:0]            r_t;
    logic signed [SW-1:0]  r_y0;
    logic signed [SW-1:0]  r_y1;
    logic signed [SW-1:0]  r_y2;
    logic signed [SW-1:0]  r_y3;
    logic signed [24:0]    r_c1;
    logic signed [27:0]    r_c2;
    logic signed [27:0]    r_c3;
    logic signed [29:0]    r_h;
    logic signed [SW-1:0]  r_v;
    logic signed [SW-1:0]  r_w;
    logic signed [26:0]    r_m8;
    logic signed [26:0]    r_s8;
    logic signed [27:0]    r_wl;
    logic signed [27:0]    r_wr;
    logic signed [SW-1:0]  r_ol;
    logic signed [SW-1:0]  r_or;
    logic signed [63:0]    r_prod;
    logic signed [63:0]    r_acc;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_out_left;
    logic signed [SW-1:0]  r_out_right;

    logic signed [31:0]    mul_a;
    logic signed [31:0]    mul_b;

    logic [31:0]           c_step;
    logic [15:0]           c_depth;
    logic [16:0]           c_mix;
    logic [16:0]           c_dry;
    logic [16:0]           c_spr;
    logic                  c_bypass;
    logic                  c_out_free;
    logic                  c_accept;
    logic [1:0]            c_pidx;
    logic signed [SW-1:0]  c_x;
    logic [31:0]           c_ph;
    logic signed [20:0]    c_dsum;
    logic [17:0]           c_dcl;
    logic signed [SW-1:0]  c_rnd28;
    logic signed [63:0]    c_tr8;
    logic signed [63:0]    c_wbase;

    ttsc_pkg::t_ram_wr      ram_wr;
    logic [AW-1:0]          ram_rd_addr;
    logic signed [SW-1:0]   ram_q;
    logic [ttsc_pkg::SINE_AW-1:0] rom_addr;
    logic signed [SW-1:0]   rom_q;

    ttsc_dly_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    ttsc_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mode   <= 3'd2;
            r_step   <= 32'd49210;
            r_base   <= 18'd1792;
            r_depth  <= 16'd27034;
            r_wet    <= 16'd14746;
            r_spread <= 16'd16384;
        end else if (i_cfg_valid) begin
            case (ttsc_pkg::t_cfg_idx'(i_cfg_index))
                ttsc_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                ttsc_pkg::CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                ttsc_pkg::CFG_STEP:   r_step   <= i_cfg_data;
                ttsc_pkg::CFG_BASE:   r_base   <= i_cfg_data[17:0];
                ttsc_pkg::CFG_DEPTH:  r_depth  <= i_cfg_data[15:0];
                ttsc_pkg::CFG_WET:    r_wet    <= i_cfg_data[15:0];
                ttsc_pkg::CFG_SPREAD: r_spread <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        c_pidx  = 2'(r_mode - 3'd1);
        c_step  = r_step;
        c_depth = r_depth;
        c_mix   = (r_wet > 16'd32768) ? 17'd32768 : {1'b0, r_wet};
        if (r_mode inside {[3'd1:3'd4]}) begin
            c_step  = ttsc_pkg::PRESET_STEP[c_pidx];
            c_depth = ttsc_pkg::PRESET_DEPTH[c_pidx];
            c_mix   = ttsc_pkg::PRESET_MIX[c_pidx];
        end
        c_dry    = 17'd32768 - c_mix;
        c_spr    = (r_spread > 16'd32768) ? 17'd32768 : {1'b0, r_spread};
        c_bypass = !r_enable || (c_mix <= 17'd3);
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign c_accept   = i_in_valid && !o_in_stall;
    assign c_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        c_x     = SW'(($signed({r_left[SW-1], r_left}) + $signed({r_right[SW-1], r_right}))
                      >>> 1);
        c_ph    = r_phase + ttsc_pkg::TAP_OFFS[r_k];
        c_dsum  = $signed({3'b000, r_base}) + 21'(ttsc_pkg::trunc_shift(r_prod, 23));
        if (c_dsum < 21'sd256) begin
            c_dcl = 18'(ttsc_pkg::DLY_MIN);
        end else if (c_dsum > 21'(ttsc_pkg::DLY_MAX)) begin
            c_dcl = 18'(ttsc_pkg::DLY_MAX);
        end else begin
            c_dcl = c_dsum[17:0];
        end
        c_rnd28 = ttsc_pkg::sat_smp(ttsc_pkg::rnd_shift(r_acc, 28));
        c_tr8   = ttsc_pkg::trunc_shift(r_prod, 8);
        c_wbase = 64'(r_m8) <<< 14;
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_EMP0: begin mul_a = 32'(c_x);   mul_b = ttsc_pkg::EMPH_B0;  end
            S_EMP1: begin mul_a = 32'(r_ex1); mul_b = ttsc_pkg::EMPH_B1;  end
            S_EMP2: begin mul_a = 32'(r_ey1); mul_b = ttsc_pkg::EMPH_NA1; end
            S_LFO2: begin
                mul_a = 32'($signed({rom_q[SW-1], rom_q}) - $signed({r_sa[SW-1], r_sa}));
                mul_b = 32'($signed({1'b0, r_ph[31-ttsc_pkg::SINE_AW -: 16]}));
            end
            S_LFO4: begin mul_a = 32'($signed({1'b0, c_depth})); mul_b = 32'(r_lfo); end
            S_HM1:  begin mul_a = 32'(r_c3); mul_b = 32'($signed({1'b0, r_t})); end
            S_HM3, S_HM5: begin mul_a = 32'(r_h); mul_b = 32'($signed({1'b0, r_t})); end
            S_LP0:  begin mul_a = 32'(r_v);         mul_b = ttsc_pkg::LP_B0;  end
            S_LP1:  begin mul_a = 32'(r_lp[r_k][0]); mul_b = ttsc_pkg::LP_B1;  end
            S_LP2:  begin mul_a = 32'(r_lp[r_k][1]); mul_b = ttsc_pkg::LP_B2;  end
            S_LP3:  begin mul_a = 32'(r_lp[r_k][2]); mul_b = ttsc_pkg::LP_NA1; end
            S_LP4:  begin mul_a = 32'(r_lp[r_k][3]); mul_b = ttsc_pkg::LP_NA2; end
            S_DE0:  begin mul_a = 32'(r_w);          mul_b = ttsc_pkg::DEEM_B0;  end
            S_DE1:  begin mul_a = 32'(r_de[r_k][0]); mul_b = ttsc_pkg::DEEM_B1;  end
            S_DE2:  begin mul_a = 32'(r_de[r_k][1]); mul_b = ttsc_pkg::DEEM_NA1; end
            S_MX1:  begin mul_a = 32'($signed({1'b0, c_spr})); mul_b = 32'(r_s8); end
            S_MX3:  begin mul_a = 32'(r_left);  mul_b = 32'($signed({1'b0, c_dry})); end
            S_MX4:  begin mul_a = 32'($signed({1'b0, c_mix})); mul_b = 32'(r_wl); end
            S_MX5:  begin mul_a = 32'(r_right); mul_b = 32'($signed({1'b0, c_dry})); end
            S_MX6:  begin mul_a = 32'($signed({1'b0, c_mix})); mul_b = 32'(r_wr); end
            default: ;
        endcase
    end

    always_comb begin
        ram_wr.en   = (r_state == S_CLR) || (r_state == S_EMP4);
        ram_wr.addr = (r_state == S_CLR) ? r_clr : r_pos;
        ram_wr.data = (r_state == S_CLR) ? '0 : c_rnd28;
        case (r_state)
            S_RD0:   ram_rd_addr = r_pos - r_n + AW'(1);
            S_RD1:   ram_rd_addr = r_pos - r_n;
            S_RD2:   ram_rd_addr = r_pos - r_n - AW'(1);
            S_RD3:   ram_rd_addr = r_pos - r_n - AW'(2);
            default: ram_rd_addr = r_pos;
        endcase
        rom_addr = (r_state == S_LFO1) ? r_ph[31 -: ttsc_pkg::SINE_AW] + 10'd1
                                       : c_ph[31 -: ttsc_pkg::SINE_AW];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_k         <= '0;
            r_byp       <= 1'b0;
            r_ex1       <= '0;
            r_ey1       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_lp[i][j] <= '0;
                end
                r_de[i][0] <= '0;
                r_de[i][1] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (c_accept) begin
                        r_left  <= i_left_in;
                        r_right <= i_right_in;
                        r_byp   <= c_bypass;
                        if (c_bypass) begin
                            r_ol    <= i_left_in;
                            r_or    <= i_right_in;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_EMP0;
                        end
                    end
                end
                S_EMP0: begin
                    r_phase <= r_phase + c_step;
                    r_x     <= c_x;
                    r_state <= S_EMP1;
                end
                S_EMP1: begin r_acc <= r_prod;         r_state <= S_EMP2; end
                S_EMP2: begin r_acc <= r_acc + r_prod; r_state <= S_EMP3; end
                S_EMP3: begin r_acc <= r_acc + r_prod; r_state <= S_EMP4; end
                S_EMP4: begin
                    r_ex1   <= r_x;
                    r_ey1   <= c_rnd28;
                    r_k     <= '0;
                    r_state <= S_LFO0;
                end
                S_LFO0: begin r_ph <= c_ph;  r_state <= S_LFO1; end
                S_LFO1: begin r_sa <= rom_q; r_state <= S_LFO2; end
                S_LFO2: r_state <= S_LFO3;
                S_LFO3: begin
                    r_lfo   <= SW'(64'(r_sa) + ttsc_pkg::trunc_shift(r_prod, 16));
                    r_state <= S_LFO4;
                end
                S_LFO4: r_state <= S_LFO5;
                S_LFO5: begin
                    r_n     <= c_dcl[17:8];
                    r_t     <= c_dcl[7:0];
                    r_state <= S_RD0;
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin r_y0 <= ram_q; r_state <= S_RD2; end
                S_RD2: begin r_y1 <= ram_q; r_state <= S_RD3; end
                S_RD3: begin r_y2 <= ram_q; r_state <= S_RD4; end
                S_RD4: begin r_y3 <= ram_q; r_state <= S_RD5; end
                S_RD5: r_state <= S_HM0;
                S_HM0: begin
                    r_c1 <= 25'(r_y2) - 25'(r_y0);
                    r_c2 <= 28'(28'(r_y0) * 28'sd2 - 28'(r_y1) * 28'sd5
                                + 28'(r_y2) * 28'sd4 - 28'(r_y3));
                    r_c3 <= 28'(28'(r_y3) - 28'(r_y0) + (28'(r_y1) - 28'(r_y2)) * 28'sd3);
                    r_state <= S_HM1;
                end
                S_HM1: r_state <= S_HM2;
                S_HM2: begin r_h <= 30'(c_tr8 + 64'(r_c2)); r_state <= S_HM3; end
                S_HM3: r_state <= S_HM4;
                S_HM4: begin r_h <= 30'(c_tr8 + 64'(r_c1)); r_state <= S_HM5; end
                S_HM5: r_state <= S_HM6;
                S_HM6: begin
                    r_v <= ttsc_pkg::sat_smp(64'(r_y1) + ttsc_pkg::trunc_shift(c_tr8, 1));
                    r_state <= S_LP0;
                end
                S_LP0: r_state <= S_LP1;
                S_LP1: begin r_acc <= r_prod;         r_state <= S_LP2; end
                S_LP2: begin r_acc <= r_acc + r_prod; r_state <= S_LP3; end
                S_LP3: begin r_acc <= r_acc + r_prod; r_state <= S_LP4; end
                S_LP4: begin r_acc <= r_acc + r_prod; r_state <= S_LP5; end
                S_LP5: begin r_acc <= r_acc + r_prod; r_state <= S_LP6; end
                S_LP6: begin
                    r_lp[r_k][1] <= r_lp[r_k][0];
                    r_lp[r_k][0] <= r_v;
                    r_lp[r_k][3] <= r_lp[r_k][2];
                    r_lp[r_k][2] <= c_rnd28;
                    r_w          <= c_rnd28;
                    r_state      <= S_DE0;
                end
                S_DE0: r_state <= S_DE1;
                S_DE1: begin r_acc <= r_prod;         r_state <= S_DE2; end
                S_DE2: begin r_acc <= r_acc + r_prod; r_state <= S_DE3; end
                S_DE3: begin r_acc <= r_acc + r_prod; r_state <= S_DE4; end
                S_DE4: begin
                    r_de[r_k][0] <= r_w;
                    r_de[r_k][1] <= c_rnd28;
                    r_tap[r_k]   <= c_rnd28;
                    if (r_k == 2'd2) begin
                        r_state <= S_MX0;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_LFO0;
                    end
                end
                S_MX0: begin
                    r_m8 <= 27'(r_tap[0]) + 27'(r_tap[1]) + 27'(r_tap[2]) * 27'sd2;
                    r_s8 <= (27'(r_tap[0]) - 27'(r_tap[1])) * 27'sd3;
                    r_state <= S_MX1;
                end
                S_MX1: r_state <= S_MX2;
                S_MX2: begin
                    r_wl    <= 28'(ttsc_pkg::rnd_shift(c_wbase + r_prod, 17));
                    r_wr    <= 28'(ttsc_pkg::rnd_shift(c_wbase - r_prod, 17));
                    r_state <= S_MX3;
                end
                S_MX3: r_state <= S_MX4;
                S_MX4: begin r_acc <= r_prod; r_state <= S_MX5; end
                S_MX5: begin
                    r_ol    <= ttsc_pkg::sat_smp(ttsc_pkg::rnd_shift(r_acc + r_prod, 15));
                    r_state <= S_MX6;
                end
                S_MX6: begin r_acc <= r_prod; r_state <= S_MX7; end
                S_MX7: begin
                    r_or    <= ttsc_pkg::sat_smp(ttsc_pkg::rnd_shift(r_acc + r_prod, 15));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register can take the beat
                    if (c_out_free) begin
                        r_out_left  <= r_ol;
                        r_out_right <= r_or;
                        r_out_valid <= 1'b1;
                        if (!r_byp) begin
                            r_pos <= r_pos + AW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_left;
    assign o_right_out = r_out_right;

`ifndef ASSERT_OFF
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_accept |=> o_in_stall)
        else $error("input taken twice in a row");

    a_mix_after_last_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MX0) |-> (r_k == 2'd2))
        else $error("mix started before all taps done");

    a_pos_moves_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != $past(r_pos)) |-> $past(r_state == S_OUT && !r_byp))
        else $error("write pointer moved outside a processed result");
`endif

endmodule

`default_nettype wire

[hdl/ttsc_dly_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttsc_dly_ram (
    input  wire logic                              i_clk,
    input  wire ttsc_pkg::t_ram_wr                 i_wr,
    input  wire logic [ttsc_pkg::DLY_AW-1:0]       i_rd_addr,
    output logic signed [ttsc_pkg::SW-1:0]         o_rd_data
);

    logic signed [ttsc_pkg::SW-1:0] mem [ttsc_pkg::DELAY_DEPTH];
    logic signed [ttsc_pkg::SW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

[hdl/ttsc_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttsc_sine_rom (
    input  wire logic                          i_clk,
    input  wire logic [ttsc_pkg::SINE_AW-1:0]  i_addr,
    output logic signed [ttsc_pkg::SW-1:0]     o_data
);

    logic signed [ttsc_pkg::SW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        r_q <= ttsc_pkg::SINE_TAB[i_addr];
    end

    assign o_data = r_q;

endmodule

`default_nettype wire

[sim/three_tap_stereo_chorus_core_test.sv]
`timescale 1ns / 1ps

module three_tap_stereo_chorus_core_test;

    class chorus_scoreboard;
        typedef struct {
            logic signed [23:0] l;
            logic signed [23:0] r;
        } t_pair;

        bit        en;
        bit [2:0]  mode;
        bit [31:0] step;
        bit [17:0] base;
        bit [15:0] depth;
        bit [15:0] wet;
        bit [15:0] spread;
        bit [31:0] phase;
        longint    store [1024];
        int        wpos;
        longint    emph_x;
        longint    emph_y;
        longint    lp_hist [12];
        longint    de_hist [6];
        longint    sine [1024];
        t_pair     expected_q [$];
        int        errors;
        int        checked;
        int        wet_beats;

        function new();
            for (int i = 0; i < 1024; i++) begin
                sine[i] = sine_point(32'((64'(i) << 32) / 1024));
            end
            en = 0; mode = 2; step = 49210; base = 1792; depth = 27034;
            wet = 14746; spread = 16384; phase = 0; wpos = 0;
            emph_x = 0; emph_y = 0;
            foreach (store[i]) store[i] = 0;
            foreach (lp_hist[i]) lp_hist[i] = 0;
            foreach (de_hist[i]) de_hist[i] = 0;
        endfunction

        function longint sine_point(bit [31:0] u);
            longint unsigned dv [6] = '{156, 110, 72, 42, 20, 6};
            longint unsigned r, x, x2, t, s;
            r = u[29:0];
            if (u[30]) r = 64'h4000_0000 - r;
            x  = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            for (int k = 0; k < 6; k++) begin
                t = 64'd1073741824 - ((x2 * t) >> 30) / dv[k];
            end
            s = (((x * t) >> 30) + 64) >> 7;
            if (s > 8388607) s = 8388607;
            return u[31] ? -longint'(s) : longint'(s);
        endfunction

        function longint clip(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function longint round_q(longint a, int sh);
            return (a + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function longint past(int back);
            return store[(wpos + 1024 - back) % 1024];
        endfunction

        function longint hermite(longint d);
            longint y0, y1, y2, y3, c1, c2, c3, acc, t;
            int n;
            if (d < 256) d = 256;
            if (d > 1022 * 256 - 1) d = 1022 * 256 - 1;
            n = int'(d >>> 8);
            t = d & 255;
            y0 = past(n - 1); y1 = past(n); y2 = past(n + 1); y3 = past(n + 2);
            c1 = y2 - y0;
            c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
            c3 = (y3 - y0) + 3 * (y1 - y2);
            acc = (c3 * t) / 256 + c2;
            acc = (acc * t) / 256 + c1;
            acc = (acc * t) / 256;
            return clip(y1 + acc / 2);
        endfunction

        function void set_reg(ttsc_pkg::t_cfg_idx idx, bit [31:0] v);
            case (idx)
                ttsc_pkg::CFG_ENABLE: en = v[0];
                ttsc_pkg::CFG_MODE:   mode = v[2:0];
                ttsc_pkg::CFG_STEP:   step = v;
                ttsc_pkg::CFG_BASE:   base = v[17:0];
                ttsc_pkg::CFG_DEPTH:  depth = v[15:0];
                ttsc_pkg::CFG_WET:    wet = v[15:0];
                ttsc_pkg::CFG_SPREAD: spread = v[15:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [23:0] li, logic signed [23:0] ri);
            longint unsigned rate_mhz [4] = '{400, 550, 750, 1100};
            longint unsigned depth_us [4] = '{1500, 2200, 3200, 4500};
            longint unsigned mix_pm [4] = '{350, 450, 550, 650};
            bit [31:0] offs [3] = '{32'h0, 32'h5555_5555, 32'hAAAA_AAAB};
            longint inl, inr, stp, dep, mix, spr, x, y, v, w, lfo, d, a, b;
            longint taps [3];
            longint m8, s8, wl, wr;
            bit [63:0] p;
            int idx;
            t_pair res;
            inl = li; inr = ri;
            stp = step; dep = depth; mix = wet;
            spr = (spread > 32768) ? 32768 : spread;
            if (mode >= 1 && mode <= 4) begin
                stp = ((rate_mhz[mode-1] << 32) + 24000000) / 48000000;
                dep = (depth_us[mode-1] * 48000 * 256 + 500000) / 1000000;
                mix = (mix_pm[mode-1] * 32768 + 500) / 1000;
            end
            if (mix > 32768) mix = 32768;
            if (!en || mix <= 3) begin
                res.l = li; res.r = ri;
                expected_q.push_back(res);
                return;
            end
            wet_beats++;
            phase = phase + 32'(stp);
            x = (inl + inr) >>> 1;
            y = clip(round_q(485683137 * x - 383307578 * emph_x + 166059891 * emph_y, 28));
            emph_x = x; emph_y = y;
            store[wpos] = y;
            for (int k = 0; k < 3; k++) begin
                p = 64'(32'(phase + offs[k])) * 1024;
                idx = int'(p[41:32]);
                a = sine[idx];
                b = sine[(idx + 1) % 1024];
                lfo = a + (b - a) * longint'(p[31:16]) / 65536;
                d = longint'(base) + (dep * lfo) / 8388608;
                v = hermite(d);
                w = clip(round_q(54549064 * v + 109098128 * lp_hist[4*k]
                                 + 54549064 * lp_hist[4*k+1]
                                 + 103365287 * lp_hist[4*k+2]
                                 - 53125927 * lp_hist[4*k+3], 28));
                lp_hist[4*k+1] = lp_hist[4*k]; lp_hist[4*k] = v;
                lp_hist[4*k+3] = lp_hist[4*k+2]; lp_hist[4*k+2] = w;
                v = clip(round_q(148363392 * w - 91780756 * de_hist[2*k]
                                 + 211852824 * de_hist[2*k+1], 28));
                de_hist[2*k] = w; de_hist[2*k+1] = v;
                taps[k] = v;
            end
            wpos = (wpos + 1) % 1024;
            m8 = taps[0] + taps[1] + 2 * taps[2];
            s8 = 3 * (taps[0] - taps[1]);
            wl = round_q(m8 * 16384 + spr * s8, 17);
            wr = round_q(m8 * 16384 - spr * s8, 17);
            res.l = 24'(clip(round_q(inl * (32768 - mix) + mix * wl, 15)));
            res.r = 24'(clip(round_q(inr * (32768 - mix) + mix * wr, 15)));
            expected_q.push_back(res);
        endfunction

        function void check_result(logic signed [23:0] lo, logic signed [23:0] ro);
            t_pair e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output beat L=%0d R=%0d", $time, lo, ro);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (lo !== e.l) begin
                $display("%0t: left_out expected %0d actual %0d", $time, e.l, lo);
                errors++;
            end
            if (ro !== e.r) begin
                $display("%0t: right_out expected %0d actual %0d", $time, e.r, ro);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [23:0] i_left_in;
    logic signed [23:0] i_right_in;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    chorus_scoreboard sb;
    bit quiet;
    bit long_hold;
    int sent;

    three_tap_stereo_chorus_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_left_out (o_left_out),
        .o_right_out(o_right_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_left_out, o_right_out);
        end
    end

    // receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (600) @(negedge i_clk);
                long_hold = 0;
                i_out_stall <= 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                i_out_stall <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
        int gap;
        gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 16);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(l, r);
        sent++;
    endtask

    task automatic cfg_write(ttsc_pkg::t_cfg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_all(logic en, logic [2:0] mode, logic [31:0] stp, logic [31:0] bas,
                           logic [31:0] dep, logic [31:0] wt, logic [31:0] spr);
        drain();
        cfg_write(ttsc_pkg::CFG_ENABLE, {31'd0, en});
        cfg_write(ttsc_pkg::CFG_MODE, {29'd0, mode});
        cfg_write(ttsc_pkg::CFG_STEP, stp);
        cfg_write(ttsc_pkg::CFG_BASE, bas);
        cfg_write(ttsc_pkg::CFG_DEPTH, dep);
        cfg_write(ttsc_pkg::CFG_WET, wt);
        cfg_write(ttsc_pkg::CFG_SPREAD, spr);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2, 3: return 24'($signed($urandom_range(0, 8191)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int n_items;
        sb = new();
        i_clk = 0; i_rst_n = 0; i_in_valid = 0; i_out_stall = 0;
        i_left_in = 0; i_right_in = 0; i_cfg_valid = 0; i_cfg_index = ttsc_pkg::CFG_ENABLE;
        i_cfg_data = 0; quiet = 0; long_hold = 0; sent = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bypass after reset, then default preset with extreme samples
        send_pair(24'sh7FFFFF, 24'sh800000);
        send_pair(24'sh000001, -24'sd1);
        drain();
        cfg_write(ttsc_pkg::CFG_ENABLE, 32'd1);
        send_pair(24'sh7FFFFF, 24'sh7FFFFF);
        send_pair(24'sh800000, 24'sh800000);
        send_pair(24'sh7FFFFF, 24'sh800000);
        send_pair(24'sh000000, 24'sh000000);
        send_pair(24'sh555555, 24'shAAAAAA);
        // manual, shortest delay, full wet and spread, max step
        set_all(1, 0, 32'hFFFF_FFFF, 256, 0, 32768, 32768);
        repeat (4) send_pair(rand_sample(), rand_sample());
        // longest delay, oversized shares saturate, base below min clamps
        set_all(1, 0, 32'h1234_5678, 261376, 61440, 32'h0000_FFFF, 32'h0000_FFFF);
        repeat (3) send_pair(24'sh7FFFFF, 24'sh800000);
        set_all(1, 0, 32'd0, 32'h3FFFF, 32'hFFFF, 40000, 0);
        send_pair(24'sh400000, 24'shC00000);
        set_all(1, 0, 32'd77777, 0, 61440, 3, 16384);  // wet of 3 bypasses
        send_pair(24'sh123456, 24'shFEDCBA);
        drain();
        cfg_write(ttsc_pkg::CFG_WET, 4);
        send_pair(24'sh123456, 24'shFEDCBA);
        set_all(1, 7, 32'd300000, 1000, 20000, 20000, 8000);  // unknown preset
        send_pair(24'sh7FFFFF, 24'sh000000);
        for (int m = 1; m <= 4; m++) begin
            drain();
            cfg_write(ttsc_pkg::CFG_MODE, m);
            send_pair(rand_sample(), rand_sample());
        end

        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph == 9);
            if ($urandom_range(0, 2) == 0) begin
                set_all($urandom_range(0, 7) != 0, 3'($urandom_range(1, 7)), $urandom,
                        $urandom_range(0, 262143), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                set_all(1, 0, $urandom_range(0, 400000), $urandom_range(256, 30000),
                        $urandom_range(0, 61440), $urandom_range(4, 32768),
                        $urandom_range(0, 32768));
            end
            if (ph == 2) long_hold = 1;
            n_items = 53;
            repeat (n_items) send_pair(rand_sample(), rand_sample());
        end

        drain();
        repeat (120) @(posedge i_clk);
        $display("Sent %0d sample pairs (%0d through the effect), checked %0d outputs.",
                 sent, sb.wet_beats, sb.checked);
        $display("Covered bypass, all presets, delay and share limits, stalls and gaps.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
